### rtl/mfdf_pkg.sv
// ----------------------------------------------------------------------------
// mfdf_pkg
// Shared widths, codes and types of the mesh frame duplicate filter.
// ----------------------------------------------------------------------------
`default_nettype none

package mfdf_pkg;

    localparam int ADDR_W         = 48;
    localparam int ID_W           = 16;
    localparam int LEN_W          = 8;
    localparam int VERDICT_W      = 3;
    localparam int CFG_DATA_W     = 64;
    localparam int CFG_INDEX_W    = 2;
    localparam int NAME_MAX_BYTES = 20;
    localparam int NAME_W         = 8 * NAME_MAX_BYTES;

    // Result codes
    typedef enum logic [VERDICT_W-1:0] {
        V_ACCEPT     = 3'd0,
        V_BAD_LENGTH = 3'd1,
        V_OWN_FRAME  = 3'd2,
        V_WRONG_NET  = 3'd3,
        V_DUPLICATE  = 3'd4,
        V_CLEARED    = 3'd5
    } verdict_t;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LOCAL_ADDRESS = 2'd0,
        CFG_NET_NAME_LOW  = 2'd1,
        CFG_NET_NAME_MID  = 2'd2,
        CFG_NET_NAME_HIGH = 2'd3
    } cfg_index_t;

    // Input command codes
    localparam logic CMD_CHECK = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // One history entry
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [ADDR_W-1:0] sender;
    } entry_t;

    // Per-cell control
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

    // One result transaction
    typedef struct packed {
        logic              accepted;
        verdict_t          verdict;
        logic [ADDR_W-1:0] origin;
        logic [ID_W-1:0]   id;
        logic [ADDR_W-1:0] hop;
    } result_t;

endpackage

`default_nettype wire

### rtl/mfdf_in_if.sv
// ----------------------------------------------------------------------------
// mfdf_in_if
// Frame header / command channel, valid-ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfdf_in_if
    import mfdf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [LEN_W-1:0]  frame_length;
    logic [ADDR_W-1:0] origin_address;
    logic [ID_W-1:0]   frame_id;
    logic [63:0]       name_word_low;
    logic [63:0]       name_word_mid;
    logic [31:0]       name_word_high;
    logic [ADDR_W-1:0] hop_address;

    modport source (
        output valid, cmd, frame_length, origin_address, frame_id,
               name_word_low, name_word_mid, name_word_high, hop_address,
        input  ready
    );

    modport sink (
        input  valid, cmd, frame_length, origin_address, frame_id,
               name_word_low, name_word_mid, name_word_high, hop_address,
        output ready
    );
endinterface

`default_nettype wire

### rtl/mfdf_out_if.sv
// ----------------------------------------------------------------------------
// mfdf_out_if
// Verdict channel, valid-ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfdf_out_if
    import mfdf_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 accepted;
    logic [VERDICT_W-1:0] verdict;
    logic [ADDR_W-1:0]    out_origin;
    logic [ID_W-1:0]      out_id;
    logic [ADDR_W-1:0]    out_hop;

    modport source (
        output valid, accepted, verdict, out_origin, out_id, out_hop,
        input  ready
    );

    modport sink (
        input  valid, accepted, verdict, out_origin, out_id, out_hop,
        output ready
    );
endinterface

`default_nettype wire

### rtl/mesh_frame_duplicate_filter_core.sv
// ----------------------------------------------------------------------------
// mesh_frame_duplicate_filter_core
// Checks received mesh frame headers for length, own origin, network name and
// recent (ID, sender) duplicates; keeps the history in a chain of cells.
// ----------------------------------------------------------------------------
//
//  channel     | dir | handshake      | payload
//  ------------+-----+----------------+-------------------------------------
//  frame_ch    | in  | valid / ready  | cmd, length, origin, id, name, hop
//  verdict_ch  | out | valid / ready  | accepted, verdict, origin, id, hop
//  cfg         | in  | cfg_we         | cfg_index, cfg_wdata
//
//  One transaction per cycle while ready is high. Checks and the parallel
//  compare against every history cell happen in the accept cycle; the result
//  is registered into the two-entry output buffer, which keeps frame_ch ready
//  while one result waits; ready drops only when both entries are full. Reset
//  clears the configuration registers, the history and the buffer valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module mesh_frame_duplicate_filter_core
    import mfdf_pkg::*;
#(
    parameter int HISTORY_DEPTH = 10,
    parameter int FRAME_BYTES   = 240,
    parameter int NAME_BYTES    = 20
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    mfdf_in_if.sink                     frame_ch,
    mfdf_out_if.source                  verdict_ch
);

    // Configuration registers
    logic [ADDR_W-1:0] local_address_reg;
    logic [63:0]       net_name_low_reg;
    logic [63:0]       net_name_mid_reg;
    logic [31:0]       net_name_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_address_reg <= '0;
            net_name_low_reg  <= '0;
            net_name_mid_reg  <= '0;
            net_name_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LOCAL_ADDRESS: local_address_reg <= cfg_wdata[ADDR_W-1:0];
                CFG_NET_NAME_LOW:  net_name_low_reg  <= cfg_wdata;
                CFG_NET_NAME_MID:  net_name_mid_reg  <= cfg_wdata;
                CFG_NET_NAME_HIGH: net_name_high_reg <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    // Handshake
    logic space;
    logic in_fire;

    assign frame_ch.ready = space;
    assign in_fire        = frame_ch.valid && space;

    // Network name compare, NUL-terminated, over NAME_BYTES bytes
    logic [NAME_W-1:0] local_name;
    logic [NAME_W-1:0] frame_name;
    logic              names_differ;

    assign local_name = {net_name_high_reg, net_name_mid_reg, net_name_low_reg};
    assign frame_name = {frame_ch.name_word_high, frame_ch.name_word_mid,
                         frame_ch.name_word_low};

    always_comb
    begin
        logic ended;
        ended        = 1'b0;
        names_differ = 1'b0;
        for (int i = 0; i < NAME_BYTES; i++)
        begin
            if (!ended && (local_name[8*i +: 8] != frame_name[8*i +: 8]))
            begin
                names_differ = 1'b1;
            end
            if (local_name[8*i +: 8] == 8'd0)
            begin
                ended = 1'b1;
            end
        end
    end

    // History chain
    entry_t                   key;
    entry_t                   chain [HISTORY_DEPTH+1];
    logic [HISTORY_DEPTH-1:0] match_vec;
    cell_ctl_t                ctl;

    assign key.id     = frame_ch.frame_id;
    assign key.sender = frame_ch.origin_address;
    assign chain[0]   = key;

    genvar g;
    generate
        for (g = 0; g < HISTORY_DEPTH; g++)
        begin : g_cell
            mfdf_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctl   (ctl),
                .prev  (chain[g]),
                .key   (key),
                .entry (chain[g+1]),
                .match (match_vec[g])
            );
        end
    endgenerate

    // Checks in priority order
    verdict_t verdict;
    result_t  push_data;

    always_comb
    begin
        if (frame_ch.cmd == CMD_CLEAR)
        begin
            verdict = V_CLEARED;
        end
        else if (frame_ch.frame_length != LEN_W'(FRAME_BYTES))
        begin
            verdict = V_BAD_LENGTH;
        end
        else if (frame_ch.origin_address == local_address_reg)
        begin
            verdict = V_OWN_FRAME;
        end
        else if ((net_name_low_reg[7:0] != 8'd0) && names_differ)
        begin
            verdict = V_WRONG_NET;
        end
        else if (|match_vec)
        begin
            verdict = V_DUPLICATE;
        end
        else
        begin
            verdict = V_ACCEPT;
        end
    end

    assign ctl.clear = in_fire && (verdict == V_CLEARED);
    assign ctl.shift = in_fire && (verdict == V_ACCEPT);

    always_comb
    begin
        push_data          = '0;
        push_data.verdict  = verdict;
        if (verdict == V_ACCEPT)
        begin
            push_data.accepted = 1'b1;
            push_data.origin   = frame_ch.origin_address;
            push_data.id       = frame_ch.frame_id;
            push_data.hop      = frame_ch.hop_address;
        end
    end

    mfdf_out_buffer u_out_buffer (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_fire),
        .push_data (push_data),
        .space     (space),
        .out_ch    (verdict_ch)
    );

    // Any history content left, for checking the clear
    logic hist_nonzero;

    always_comb
    begin
        hist_nonzero = 1'b0;
        for (int i = 1; i <= HISTORY_DEPTH; i++)
        begin
            hist_nonzero = hist_nonzero || (chain[i] != '0);
        end
    end

`ifndef SYNTHESIS
    // a clear transaction leaves an all-zero history
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear |=> !hist_nonzero)
        else $error("history not cleared");

    // an accepted frame lands in the newest cell
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.shift |=> (chain[1].id == $past(frame_ch.frame_id)) &&
                      (chain[1].sender == $past(frame_ch.origin_address)))
        else $error("accepted frame not pushed into history");

    // input stalls only while a result is waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        !frame_ch.ready |-> verdict_ch.valid)
        else $error("input stalled with empty output");

    // accepted flag agrees with the verdict code
    assert property (@(posedge clk) disable iff (!rst_n)
        verdict_ch.valid |-> (verdict_ch.accepted == (verdict_ch.verdict == V_ACCEPT)))
        else $error("accepted flag and verdict disagree");
`endif

endmodule

`default_nettype wire

### rtl/mfdf_cell.sv
// ----------------------------------------------------------------------------
// mfdf_cell
// One history slot: holds an (ID, sender) pair, compares it with the key and
// takes its neighbor's entry when the history shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module mfdf_cell
    import mfdf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cell_ctl_t ctl,
    input  wire entry_t    prev,
    input  wire entry_t    key,
    output entry_t         entry,
    output logic           match
);

    entry_t entry_reg;
    entry_t entry_next;

    // clear wins over shift; both come from separate transactions anyway
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.clear)
        begin
            entry_next = '0;
        end
        else if (ctl.shift)
        begin
            entry_next = prev;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;
    assign match = (entry_reg == key);

endmodule

`default_nettype wire

### rtl/mfdf_out_buffer.sv
// ----------------------------------------------------------------------------
// mfdf_out_buffer
// Two-entry result buffer (output register plus skid register) that drives
// the verdict channel.
// ----------------------------------------------------------------------------
`default_nettype none

module mfdf_out_buffer
    import mfdf_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         space,
    mfdf_out_if.source   out_ch
);

    logic    head_valid_reg;
    logic    head_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t head_reg;
    result_t head_next;
    result_t skid_reg;
    result_t skid_next;
    logic    pop;

    assign pop   = head_valid_reg && out_ch.ready;
    assign space = !skid_valid_reg;

    // head refills from skid first, then from the new transaction
    always_comb
    begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                head_next       = skid_reg;
                skid_next       = push_data;
                skid_valid_next = push;
            end
            else
            begin
                head_next       = push_data;
                head_valid_next = push;
            end
        end
        else if (push)
        begin
            if (head_valid_reg)
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
            else
            begin
                head_next       = push_data;
                head_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign out_ch.valid      = head_valid_reg;
    assign out_ch.accepted   = head_reg.accepted;
    assign out_ch.verdict    = head_reg.verdict;
    assign out_ch.out_origin = head_reg.origin;
    assign out_ch.out_id     = head_reg.id;
    assign out_ch.out_hop    = head_reg.hop;

endmodule

`default_nettype wire
